// File: hw/rtl/mm4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

	// matrix geometry
	localparam int DIM       = 4;
	localparam int NUM_ELEMS = DIM * DIM;
	localparam int DIM_W     = $clog2(DIM);
	localparam int IDX_W     = $clog2(NUM_ELEMS);

	// number format
	localparam int FRAC_BITS = 16;
	localparam int ELEM_W    = 32;
	localparam int CIDX_W    = 4;
	localparam int PROD_W    = 2 * ELEM_W;
	localparam int ACC_W     = PROD_W + $clog2(DIM);
	localparam int SH_W      = ACC_W - FRAC_BITS;

	localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

	// cycles between the last read of an element and its result load
	localparam int DRAIN_CYC = 3;
	localparam int DRAIN_W   = $clog2(DRAIN_CYC);

	// input word: one element of A and of B at the same index
	typedef struct packed {
		logic signed [ELEM_W-1:0] a_elem;
		logic signed [ELEM_W-1:0] b_elem;
	} in_word_t;

	// result word: one element of C
	typedef struct packed {
		logic signed [ELEM_W-1:0] c_elem;
		logic [CIDX_W-1:0]        c_index;
		logic                     c_last;
		logic                     c_saturated;
	} out_word_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr_a;
		logic [IDX_W-1:0] rd_addr_b;
		logic             acc_clr;
		logic             out_load;
		logic [IDX_W-1:0] elem;
		logic             last;
	} mm4_cmd_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_READ,
		ST_DRAIN
	} mm4_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/matrix_multiply_4x4.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_4x4
// Q16.16 fixed-point 4x4 matrix multiplier, C = A x B, column-major.
//
// Load channel (load_valid/load_ready/load_data): sixteen words, each with
// element i of A and element i of B, in index order 0 to 15. One word is
// taken per cycle while the block is loading.
// Result channel (res_valid/res_ready/res_data): after the sixteenth word the
// block returns the sixteen elements of C in index order, c_last set on the
// final one, c_saturated set where the value was clamped to 32 bits.
// Each element is four multiply-accumulates through one shared MAC fed by
// the registered reads of the A and B stores: the reads, then a pipeline
// drain through the product register and the accumulator before the result
// load. No load word is taken while the block computes.
// The result register holds a word until it is taken; a stalled receiver
// stops the next element at the end of its drain. Loading of the next
// matrix pair starts while the last result still waits.
// Reset clears the counters and the result valid flag; the stores are not
// cleared, every entry is rewritten before it is used.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4 import mm4_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        load_valid,
	output logic       load_ready,
	input  in_word_t   load_data,
	output logic       res_valid,
	input  wire        res_ready,
	output out_word_t  res_data
);

	mm4_cmd_t cmd;

	// sequencer
	mm4_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (load_valid),
		.load_ready (load_ready),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.cmd        (cmd)
	);

	// stores, mac and result register
	mm4_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.load_data (load_data),
		.res_data  (res_data)
	);

endmodule
`default_nettype wire

// File: hw/rtl/mm4_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mm4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: hw/rtl/mm4_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_ctrl
// Sequencer: load counting, read address generation for the dot products,
// pipeline drain timing and the result valid flag.
// ----------------------------------------------------------------------------
module mm4_ctrl import mm4_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       load_valid,
	output logic      load_ready,
	output logic      res_valid,
	input  wire       res_ready,
	output mm4_cmd_t  cmd
);

	mm4_state_t         state_q, state_d;
	logic [IDX_W-1:0]   load_cnt_q;
	logic [DIM_W-1:0]   k_q;
	logic [DIM_W-1:0]   row_q;
	logic [DIM_W-1:0]   col_q;
	logic [IDX_W-1:0]   elem_q;
	logic [DRAIN_W-1:0] drain_q;
	logic               res_valid_q;
	logic               load_acc;
	logic               out_free;
	logic               k_last;
	logic               drain_last;
	logic               elem_last;

	assign load_ready = (state_q == ST_LOAD);
	assign load_acc   = load_valid & load_ready;
	assign res_valid  = res_valid_q;
	assign out_free   = ~res_valid_q | res_ready;
	assign k_last     = (k_q == DIM_W'(DIM - 1));
	assign drain_last = (drain_q == DRAIN_W'(DRAIN_CYC - 1));
	assign elem_last  = (elem_q == IDX_W'(NUM_ELEMS - 1));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.wr_addr   = load_cnt_q;
		cmd.rd_addr_a = IDX_W'(k_q * DIM + row_q);
		cmd.rd_addr_b = IDX_W'(col_q * DIM + k_q);
		cmd.elem      = elem_q;
		cmd.last      = elem_last;
		case (state_q)
			ST_LOAD: begin
				cmd.wr_en = load_acc;
				if (load_acc && load_cnt_q == IDX_W'(NUM_ELEMS - 1)) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en   = 1'b1;
				cmd.acc_clr = (k_q == '0);
				if (k_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_last && out_free) begin
					cmd.out_load = 1'b1;
					state_d      = elem_last ? ST_LOAD : ST_READ;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// counters and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q  <= '0;
			k_q         <= '0;
			row_q       <= '0;
			col_q       <= '0;
			elem_q      <= '0;
			drain_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// load index wraps after the last element
			if (load_acc) begin
				if (load_cnt_q == IDX_W'(NUM_ELEMS - 1)) begin
					load_cnt_q <= '0;
				end else begin
					load_cnt_q <= load_cnt_q + 1'b1;
				end
			end

			// dot product term index
			if (cmd.rd_en) begin
				k_q <= k_last ? '0 : k_q + 1'b1;
			end

			// drain wait after the last read
			if (state_q == ST_DRAIN) begin
				if (cmd.out_load) begin
					drain_q <= '0;
				end else if (!drain_last) begin
					drain_q <= drain_q + 1'b1;
				end
			end

			// advance row, column and element on each result
			if (cmd.out_load) begin
				if (elem_last) begin
					row_q  <= '0;
					col_q  <= '0;
					elem_q <= '0;
				end else begin
					elem_q <= elem_q + 1'b1;
					if (row_q == DIM_W'(DIM - 1)) begin
						row_q <= '0;
						col_q <= col_q + 1'b1;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
			end

			// result word valid until taken
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/mm4_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_dp
// Datapath: element stores for A and B, one multiply-accumulate unit,
// scaling with saturation and the result register.
// ----------------------------------------------------------------------------
module mm4_dp import mm4_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  mm4_cmd_t   cmd,
	input  in_word_t   load_data,
	output out_word_t  res_data
);

	logic [ELEM_W-1:0]       a_rd;
	logic [ELEM_W-1:0]       b_rd;
	logic                    rd_v_s1;
	logic                    mul_v_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_shr;
	logic [SH_W-1:0]          sh;
	logic [SH_W-ELEM_W:0]     sh_hi;
	logic                     ovf;
	logic [ELEM_W-1:0]        sat_val;
	out_word_t                res_q;

	// element stores
	mm4_ram #(.WIDTH(ELEM_W), .DEPTH(NUM_ELEMS)) u_a_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (cmd.wr_addr),
		.wdata (load_data.a_elem),
		.raddr (cmd.rd_addr_a),
		.rdata (a_rd)
	);

	mm4_ram #(.WIDTH(ELEM_W), .DEPTH(NUM_ELEMS)) u_b_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (cmd.wr_addr),
		.wdata (load_data.b_elem),
		.raddr (cmd.rd_addr_b),
		.rdata (b_rd)
	);

	// pipeline valid flags for read data and product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1  <= 1'b0;
			mul_v_s2 <= 1'b0;
		end else begin
			rd_v_s1  <= cmd.rd_en;
			mul_v_s2 <= rd_v_s1;
		end
	end

	// product register
	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			prod_s2 <= $signed(a_rd) * $signed(b_rd);
		end
	end

	// exact wide accumulator
	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (mul_v_s2) begin
			acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	// arithmetic shift by the fraction width, then clamp to 32 bits
	assign acc_shr = acc_q >>> FRAC_BITS;
	assign sh      = acc_shr[SH_W-1:0];
	assign sh_hi   = sh[SH_W-1:ELEM_W-1];
	assign ovf     = ~((&sh_hi) | ~(|sh_hi));
	assign sat_val = sh[SH_W-1] ? ELEM_MIN : ELEM_MAX;

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q.c_elem      <= ovf ? sat_val : sh[ELEM_W-1:0];
			res_q.c_index     <= CIDX_W'(cmd.elem);
			res_q.c_last      <= cmd.last;
			res_q.c_saturated <= ovf;
		end
	end

	assign res_data = res_q;

endmodule
`default_nettype wire

// File: sim/matrix_multiply_4x4_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_tb
// Loads matrix pairs word by word and checks every element of the product.
// A corner-case pair comes first, built so that each product element can be
// read off by hand (exact limits, clamping both ways, truncation of negative
// values). Random pairs follow, mostly small values with some full-range and
// extreme-valued pairs, and every product is checked against a fixed-point
// dot-product calculation kept here. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_tb;
	import mm4_pkg::*;

	localparam int RAND_PAIRS  = 27;
	localparam int CYCLE_LIMIT = 100000;
	localparam int TAIL_CYC    = 40;

	localparam logic [ELEM_W-1:0] UNIT = 1 << FRAC_BITS;

	// shifted dot-product range that still fits a 32-bit element
	localparam logic signed [67:0] SUM_MAX = 68'sh7FFF_FFFF;
	localparam logic signed [67:0] SUM_MIN = -68'sh8000_0000;

	typedef enum {FILL_SMALL, FILL_FULL, FILL_EXTREME} fill_mode_t;

	// one corner-case row: load word, and the element of C at the same index
	typedef struct packed {
		logic [ELEM_W-1:0] a_val;
		logic [ELEM_W-1:0] b_val;
		logic              typed;
		logic [ELEM_W-1:0] c_val;
		logic              clamp;
	} corner_row_t;

	// A is diagonal (1.0, -1.0, max, min), so C(r,c) = A(r,r) * B(r,c)
	corner_row_t corner_rows [NUM_ELEMS] = '{
		'{32'h0001_0000, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0},
		'{32'h0000_0000, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1},
		'{32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1},
		'{32'h0000_0000, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1},
		'{32'h0000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0},
		'{32'hFFFF_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0001, 1'b0},
		'{32'h0000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1},
		'{32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b1},
		'{32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0001, 1'b0},
		'{32'h0000_0000, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF, 1'b0},
		'{32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_7FFF, 1'b0},
		'{32'h0000_0000, 32'h0001_0000, 1'b1, 32'h8000_0000, 1'b0},
		'{32'h0000_0000, 32'h1234_5678, 1'b0, 32'h0000_0000, 1'b0},
		'{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_8000, 1'b0},
		'{32'h8000_0000, 32'hFFFF_0000, 1'b1, 32'h7FFF_FFFF, 1'b1}
	};

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      load_valid = 1'b0;
	logic      load_ready;
	in_word_t  load_data  = '0;
	logic      res_valid;
	logic      res_ready  = 1'b0;
	out_word_t res_data;

	// no idling on either side while set
	logic steady = 1'b0;

	// loaded matrices and the product elements still to arrive
	logic signed [ELEM_W-1:0] a_mat [NUM_ELEMS];
	logic signed [ELEM_W-1:0] b_mat [NUM_ELEMS];
	int unsigned              fill_count = 0;
	out_word_t                c_queue [$];

	int unsigned words_sent    = 0;
	int unsigned elems_checked = 0;
	int unsigned clamped_seen  = 0;
	int unsigned fail_count    = 0;
	int unsigned cycle_count   = 0;

	matrix_multiply_4x4 DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (load_valid),
		.load_ready (load_ready),
		.load_data  (load_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data)
	);

	always #1 clk = ~clk;

	// one element of C: exact dot product, floor shift, clamp to 32 bits
	function automatic out_word_t product_elem(int unsigned row, int unsigned col);
		logic signed [67:0] dot_sum;
		logic signed [67:0] scaled;
		logic signed [63:0] term;
		int unsigned        k;
		out_word_t          res;
		dot_sum = '0;
		for (k = 0; k < DIM; k++) begin
			term    = a_mat[k*DIM + row] * b_mat[col*DIM + k];
			dot_sum = dot_sum + term;
		end
		scaled            = dot_sum >>> FRAC_BITS;
		res.c_index       = CIDX_W'(col*DIM + row);
		res.c_last        = (col*DIM + row == NUM_ELEMS - 1);
		res.c_saturated   = 1'b1;
		if (scaled > SUM_MAX) begin
			res.c_elem = ELEM_MAX;
		end else if (scaled < SUM_MIN) begin
			res.c_elem = ELEM_MIN;
		end else begin
			res.c_elem      = scaled[ELEM_W-1:0];
			res.c_saturated = 1'b0;
		end
		return res;
	endfunction

	// store an accepted word; the last one of a pair yields the whole product
	function automatic void store_word(in_word_t w);
		int unsigned row;
		int unsigned col;
		a_mat[fill_count] = w.a_elem;
		b_mat[fill_count] = w.b_elem;
		if (fill_count == NUM_ELEMS - 1) begin
			fill_count = 0;
			for (col = 0; col < DIM; col++)
				for (row = 0; row < DIM; row++)
					c_queue.push_back(product_elem(row, col));
		end else begin
			fill_count++;
		end
	endfunction

	function automatic logic [ELEM_W-1:0] pick_value(fill_mode_t mode);
		logic signed [18:0] small_val;
		case (mode)
			FILL_SMALL: begin
				// within +-4.0
				small_val = 19'($urandom);
				return 32'(small_val);
			end
			FILL_FULL: return $urandom;
			default: begin
				case ($urandom_range(6))
					0: return ELEM_MAX;
					1: return ELEM_MIN;
					2: return '0;
					3: return UNIT;
					4: return -UNIT;
					5: return '1;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	// present one load word and hold it until taken; called at a rising edge
	task automatic send_word(input in_word_t w);
		while (!steady && $urandom_range(99) < 8) begin
			load_valid <= 1'b0;
			@(posedge clk);
		end
		load_valid <= 1'b1;
		load_data  <= w;
		@(posedge clk);
		while (!load_ready)
			@(posedge clk);
		store_word(w);
		words_sent++;
	endtask

	task automatic check_result(input out_word_t got);
		out_word_t want;
		if (c_queue.size() == 0) begin
			$display("%0t: result word with nothing pending: index %0d value %h",
				$time, got.c_index, got.c_elem);
			fail_count++;
		end else begin
			want = c_queue.pop_front();
			elems_checked++;
			if (want.c_saturated)
				clamped_seen++;
			if (got.c_elem !== want.c_elem) begin
				$display("%0t: c_elem at index %0d: expected %h, got %h",
					$time, want.c_index, want.c_elem, got.c_elem);
				fail_count++;
			end
			if (got.c_index !== want.c_index) begin
				$display("%0t: c_index: expected %0d, got %0d",
					$time, want.c_index, got.c_index);
				fail_count++;
			end
			if (got.c_last !== want.c_last) begin
				$display("%0t: c_last at index %0d: expected %b, got %b",
					$time, want.c_index, want.c_last, got.c_last);
				fail_count++;
			end
			if (got.c_saturated !== want.c_saturated) begin
				$display("%0t: c_saturated at index %0d: expected %b, got %b",
					$time, want.c_index, want.c_saturated, got.c_saturated);
				fail_count++;
			end
		end
	endtask

	// result side: check each taken word, stall at random
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			check_result(res_data);
		res_ready <= steady || ($urandom_range(99) >= 8);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d elements pending",
				cycle_count, c_queue.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// stimulus
	initial begin
		in_word_t    w;
		fill_mode_t  mode;
		int unsigned roll;
		int unsigned base;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner-case pair
		foreach (corner_rows[i]) begin
			w.a_elem = corner_rows[i].a_val;
			w.b_elem = corner_rows[i].b_val;
			send_word(w);
		end
		// hand-worked values stand in for the computed ones
		base = c_queue.size() - NUM_ELEMS;
		foreach (corner_rows[i]) begin
			if (corner_rows[i].typed) begin
				c_queue[base + i].c_elem      = corner_rows[i].c_val;
				c_queue[base + i].c_saturated = corner_rows[i].clamp;
			end
		end

		// random pairs, one stretch of them with no idling
		for (int m = 0; m < RAND_PAIRS; m++) begin
			steady <= (m >= 8 && m < 14);
			roll = $urandom_range(9);
			mode = (roll < 6) ? FILL_SMALL : (roll < 8) ? FILL_FULL : FILL_EXTREME;
			for (int i = 0; i < NUM_ELEMS; i++) begin
				w.a_elem = pick_value(mode);
				w.b_elem = pick_value(mode);
				send_word(w);
			end
		end
		load_valid <= 1'b0;

		// drain
		while (c_queue.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);

		$display("Loaded %0d words (%0d matrix pairs), checked %0d product elements,",
			words_sent, words_sent / NUM_ELEMS, elems_checked);
		$display("%0d of them clamped to the 32-bit range", clamped_seen);
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
